// File: hw/rtl/ftl_pkg.sv
// Shared types and constants for the form text lexer.
// Used by ftl_core, ftl_outq and the top level form_text_lexer; no dependencies.
`default_nettype none

package ftl_pkg;

  // Width of the running character position counter.
  localparam int POS_BITS = 32;

  // Most result records that one character can cause, and the result queue depth.
  localparam int MAX_RES     = 3;
  localparam int OUTQ_DEPTH  = 4;
  localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [15:0] LEN_MAX  = 16'hFFFF;
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // Record kinds.
  localparam logic RK_CHAR  = 1'b0;
  localparam logic RK_TOKEN = 1'b1;

  // Token kinds.
  localparam logic [2:0] TK_SYMBOL  = 3'd0;
  localparam logic [2:0] TK_STRING  = 3'd1;
  localparam logic [2:0] TK_INTEGER = 3'd2;
  localparam logic [2:0] TK_FLOAT   = 3'd3;
  localparam logic [2:0] TK_HEX     = 3'd4;
  localparam logic [2:0] TK_PUNCT   = 3'd5;
  localparam logic [2:0] TK_EOF     = 3'd6;
  localparam logic [2:0] TK_BADSTR  = 3'd7;

  // Character codes with a special meaning.
  localparam logic [7:0] CH_SPACE_END = 8'd33;
  localparam logic [7:0] CH_NUL       = 8'd0;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_LOW_E     = 8'h65;
  localparam logic [7:0] CH_ZERO      = 8'h30;

  // One result record as it leaves the block.
  typedef struct packed {
    logic        rec_kind;
    logic [2:0]  token_kind;
    logic [7:0]  char_value;
    logic [31:0] start_pos;
    logic [15:0] token_len;
    logic [23:0] line;
    logic        last;
  } rec_t;

  // All records caused by one accepted character, in order.
  typedef struct packed {
    rec_t [MAX_RES-1:0]   recs;
    logic [RES_CNT_W-1:0] count;
  } batch_t;

endpackage

`default_nettype wire

// File: hw/rtl/ftl_core.sv
// Lexer state registers and the one-character step logic of the form text lexer.
// Depends on ftl_pkg for the record types and character codes.
`default_nettype none

module ftl_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    ch,
  input  wire logic          end_of_input,
  output ftl_pkg::batch_t    batch
);
  import ftl_pkg::*;

  typedef enum logic [7:0] {
    M_IDLE  = 8'b0000_0001,
    M_SYM   = 8'b0000_0010,
    M_AT    = 8'b0000_0100,
    M_HEX   = 8'b0000_1000,
    M_INT   = 8'b0001_0000,
    M_FLT   = 8'b0010_0000,
    M_HASH  = 8'b0100_0000,
    M_QUOTE = 8'b1000_0000
  } mode_t;

  mode_t                mode, mode_next;
  logic [POS_BITS-1:0]  pos, pos_next;
  logic [POS_BITS-1:0]  tstart, tstart_next;
  logic [15:0]          tlen, tlen_next;
  logic [23:0]          lcount, lcount_next;
  logic [23:0]          sline, sline_next;
  logic [7:0]           code, code_next;
  logic                 qseen, qseen_next;

  rec_t [MAX_RES-1:0]   slot;
  logic [RES_CNT_W-1:0] n;
  logic                 idle_go;
  logic                 gap_go;
  logic [15:0]          tlen_grown;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic is_flt(input logic [7:0] c);
    return is_digit(c) || c == CH_DOT || c == CH_LOW_E || c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic rec_t mk_rec(input logic rk, input logic [2:0] tk,
                                  input logic [7:0] cv, input logic [31:0] sp,
                                  input logic [15:0] len, input logic [23:0] ln);
    rec_t r;
    r.rec_kind   = rk;
    r.token_kind = tk;
    r.char_value = cv;
    r.start_pos  = sp;
    r.token_len  = len;
    r.line       = ln;
    r.last       = 1'b0;
    return r;
  endfunction

  assign tlen_grown = (tlen != LEN_MAX) ? tlen + 16'd1 : tlen;

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    tstart_next = tstart;
    tlen_next   = tlen;
    lcount_next = lcount;
    sline_next  = sline;
    code_next   = code;
    qseen_next  = qseen;
    slot        = '0;
    n           = '0;
    idle_go     = 1'b0;
    gap_go      = 1'b0;

    if (end_of_input) begin
      unique case (mode)
        M_SYM: begin
          slot[n] = mk_rec(RK_TOKEN, TK_SYMBOL, 8'd0, 32'(tstart), tlen, sline);
          n = n + 1'b1;
        end
        M_AT: begin
          slot[n] = mk_rec(RK_TOKEN, TK_PUNCT, CH_AT, 32'(tstart), tlen, sline);
          n = n + 1'b1;
        end
        M_HEX: begin
          slot[n] = mk_rec(RK_TOKEN, TK_HEX, 8'd0, 32'(tstart), tlen, sline);
          n = n + 1'b1;
        end
        M_INT: begin
          slot[n] = mk_rec(RK_TOKEN, TK_INTEGER, 8'd0, 32'(tstart), tlen, sline);
          n = n + 1'b1;
        end
        M_FLT: begin
          slot[n] = mk_rec(RK_TOKEN, TK_FLOAT, 8'd0, 32'(tstart), tlen, sline);
          n = n + 1'b1;
        end
        M_HASH: begin
          slot[n] = mk_rec(RK_CHAR, TK_STRING, code, 32'(tstart), 16'd0, sline);
          n = n + 1'b1;
          slot[n] = mk_rec(RK_TOKEN, TK_STRING, 8'd0, 32'(tstart), tlen, sline);
          n = n + 1'b1;
        end
        M_QUOTE: begin
          slot[n] = mk_rec(RK_TOKEN, qseen ? TK_STRING : TK_BADSTR, 8'd0,
                           32'(tstart), tlen, sline);
          n = n + 1'b1;
        end
        default: begin
        end
      endcase
      mode_next  = M_IDLE;
      qseen_next = 1'b0;
      slot[n] = mk_rec(RK_TOKEN, TK_EOF, 8'd0, 32'(pos), 16'd0, lcount);
      n = n + 1'b1;
    end else begin
      pos_next = pos + 1'b1;
      unique case (mode)
        M_SYM: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_COLON || ch == CH_AT) begin
            tlen_next = tlen_grown;
          end else begin
            slot[n] = mk_rec(RK_TOKEN, TK_SYMBOL, 8'd0, 32'(tstart), tlen, sline);
            n = n + 1'b1;
            idle_go = 1'b1;
          end
        end
        M_AT: begin
          if (is_alpha(ch)) begin
            tlen_next = tlen_grown;
            mode_next = M_SYM;
          end else begin
            slot[n] = mk_rec(RK_TOKEN, TK_PUNCT, CH_AT, 32'(tstart), tlen, sline);
            n = n + 1'b1;
            idle_go = 1'b1;
          end
        end
        M_HEX: begin
          if (is_hex(ch)) begin
            tlen_next = tlen_grown;
          end else begin
            slot[n] = mk_rec(RK_TOKEN, TK_HEX, 8'd0, 32'(tstart), tlen, sline);
            n = n + 1'b1;
            idle_go = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(ch)) begin
            tlen_next = tlen_grown;
          end else if (is_flt(ch)) begin
            tlen_next = tlen_grown;
            mode_next = M_FLT;
          end else begin
            slot[n] = mk_rec(RK_TOKEN, TK_INTEGER, 8'd0, 32'(tstart), tlen, sline);
            n = n + 1'b1;
            idle_go = 1'b1;
          end
        end
        M_FLT: begin
          if (is_flt(ch)) begin
            tlen_next = tlen_grown;
          end else begin
            slot[n] = mk_rec(RK_TOKEN, TK_FLOAT, 8'd0, 32'(tstart), tlen, sline);
            n = n + 1'b1;
            idle_go = 1'b1;
          end
        end
        M_HASH: begin
          if (is_digit(ch)) begin
            // code * 10 + digit, kept to eight bits.
            code_next = {code[4:0], 3'b000} + {code[6:0], 1'b0} + (ch - CH_ZERO);
            tlen_next = tlen_grown;
          end else begin
            slot[n] = mk_rec(RK_CHAR, TK_STRING, code, 32'(tstart), 16'd0, sline);
            n = n + 1'b1;
            gap_go = 1'b1;
          end
        end
        M_QUOTE: begin
          if (qseen) begin
            qseen_next = 1'b0;
            if (ch == CH_QUOTE) begin
              slot[n] = mk_rec(RK_CHAR, TK_STRING, CH_QUOTE, 32'(tstart), 16'd0, sline);
              n = n + 1'b1;
              tlen_next = tlen_grown;
            end else begin
              gap_go = 1'b1;
            end
          end else if (ch == CH_NUL || ch == CH_LF || ch == CH_CR) begin
            slot[n] = mk_rec(RK_TOKEN, TK_BADSTR, 8'd0, 32'(tstart), tlen, sline);
            n = n + 1'b1;
            idle_go = 1'b1;
          end else if (ch == CH_QUOTE) begin
            qseen_next = 1'b1;
            tlen_next  = tlen_grown;
          end else begin
            slot[n] = mk_rec(RK_CHAR, TK_STRING, ch, 32'(tstart), 16'd0, sline);
            n = n + 1'b1;
            tlen_next = tlen_grown;
          end
        end
        default: begin
          idle_go = 1'b1;
        end
      endcase

      // After a closed segment or a code, the string may go on.
      if (gap_go) begin
        if (ch == CH_HASH) begin
          tlen_next = tlen_grown;
          mode_next = M_HASH;
          code_next = 8'd0;
        end else if (ch == CH_QUOTE) begin
          tlen_next  = tlen_grown;
          mode_next  = M_QUOTE;
          qseen_next = 1'b0;
        end else begin
          slot[n] = mk_rec(RK_TOKEN, TK_STRING, 8'd0, 32'(tstart), tlen, sline);
          n = n + 1'b1;
          idle_go = 1'b1;
        end
      end

      // Character seen between tokens.
      if (idle_go) begin
        mode_next = M_IDLE;
        if (ch < CH_SPACE_END) begin
          if (ch == CH_LF && lcount != LINE_MAX) begin
            lcount_next = lcount + 24'd1;
          end
        end else begin
          tstart_next = pos;
          sline_next  = lcount;
          tlen_next   = 16'd1;
          if (is_alpha(ch)) begin
            mode_next = M_SYM;
          end else if (ch == CH_AT) begin
            mode_next = M_AT;
          end else if (ch == CH_HASH) begin
            mode_next = M_HASH;
            code_next = 8'd0;
          end else if (ch == CH_QUOTE) begin
            mode_next  = M_QUOTE;
            qseen_next = 1'b0;
          end else if (ch == CH_DOLLAR) begin
            mode_next = M_HEX;
          end else if (ch == CH_MINUS || is_digit(ch)) begin
            mode_next = M_INT;
          end else begin
            slot[n] = mk_rec(RK_TOKEN, TK_PUNCT, ch, 32'(pos), 16'd1, lcount);
            n = n + 1'b1;
          end
        end
      end
    end

    if (n != '0) begin
      slot[n - 1'b1].last = 1'b1;
    end
    batch.recs  = slot;
    batch.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      tstart <= '0;
      tlen   <= '0;
      lcount <= 24'd1;
      sline  <= 24'd1;
      code   <= '0;
      qseen  <= 1'b0;
    end else if (take) begin
      mode   <= mode_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      tlen   <= tlen_next;
      lcount <= lcount_next;
      sline  <= sline_next;
      code   <= code_next;
      qseen  <= qseen_next;
    end
  end

  // The end marker always reports end-of-file and leaves the lexer between tokens.
  a_eof_reported: assert property (@(posedge clk) disable iff (rst)
    take && end_of_input |-> batch.count != '0)
    else $error("end marker produced no records");

  a_eof_resets_mode: assert property (@(posedge clk) disable iff (rst)
    take && end_of_input |=> mode == M_IDLE && pos == $past(pos))
    else $error("end marker left a token pending or moved the position");

endmodule

`default_nettype wire

// File: hw/rtl/ftl_outq.sv
// Result record queue of the form text lexer: takes a whole batch per cycle,
// releases one record per transfer. Depends on ftl_pkg.
`default_nettype none

module ftl_outq (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  ftl_pkg::batch_t   batch,
  output logic              room,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ftl_pkg::rec_t     head
);
  import ftl_pkg::*;

  rec_t [OUTQ_DEPTH-1:0]  q;
  logic [OUTQ_AW-1:0]     rd_ptr, rd_ptr_next;
  logic [OUTQ_AW-1:0]     wr_ptr, wr_ptr_next;
  logic [OUTQ_AW:0]       count, count_next;
  logic [OUTQ_AW:0]       push_n;
  logic                   pop;

  assign room      = count <= (OUTQ_AW + 1)'(OUTQ_DEPTH - MAX_RES);
  assign out_valid = count != '0;
  assign head      = q[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign push_n    = push ? (OUTQ_AW + 1)'(batch.count) : '0;

  assign rd_ptr_next = pop ? rd_ptr + 1'b1 : rd_ptr;
  assign wr_ptr_next = wr_ptr + push_n[OUTQ_AW-1:0];
  assign count_next  = count + push_n - (OUTQ_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push && i < int'(batch.count)) begin
        q[wr_ptr + OUTQ_AW'(i)] <= batch.recs[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count + push_n <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
    else $error("result queue overflow");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    !push && pop |=> count == $past(count) - 1'b1)
    else $error("result queue count out of step with transfers");

endmodule

`default_nettype wire

// File: hw/rtl/form_text_lexer.sv
// Top level of the form text lexer: joins the lexer step logic and the result queue.
// Depends on ftl_pkg, ftl_core and ftl_outq.
`default_nettype none

// The form text lexer takes one source character per input transfer and turns
// the text into token records (kind, start offset, length, line) plus one record
// per decoded string character. A transfer with end_of_input set carries no
// character: it flushes the pending token and reports end-of-file. A token is
// reported when the first character that cannot extend it arrives, so results
// trail the input by one character. The lexer state is updated in the cycle a
// character is accepted, so a new character can be taken every cycle while the
// queue has room. Results leave one record per output transfer from a four-entry
// record queue; one character causes up to three records, and the input stalls
// while the queue holds more than one record. With an output that is never
// stalled, characters that cause no record or one record run at one per cycle.

module form_text_lexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             rec_kind,
  output logic [2:0]       token_kind,
  output logic [7:0]       char_value,
  output logic [31:0]      start_pos,
  output logic [15:0]      token_len,
  output logic [23:0]      line,
  output logic             last
);
  import ftl_pkg::*;

  batch_t batch;
  rec_t   head;
  logic   room;
  logic   take;

  // The input side stalls only when a full batch might not fit in the queue.
  assign in_stall = !room;
  assign take     = in_valid && room;

  ftl_core u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .ch           (ch),
    .end_of_input (end_of_input),
    .batch        (batch)
  );

  ftl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .batch     (batch),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign rec_kind   = head.rec_kind;
  assign token_kind = head.token_kind;
  assign char_value = head.char_value;
  assign start_pos  = head.start_pos;
  assign token_len  = head.token_len;
  assign line       = head.line;
  assign last       = head.last;

endmodule

`default_nettype wire
